// ===== hdl/rpd_pkg.sv =====
// Package for the PCX run-length palette decoder: palette sizing, input function
// codes, the command word passed from front end to back end, and index range check.
// No dependencies.
package rpd_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
    localparam int CODE_W      = 8;
    localparam int CNT_W       = 6;
    localparam int COLOR_W     = 24;

    localparam logic [1:0] RUN_MARK   = 2'b11;
    localparam logic       FUNC_WRITE = 1'b0;
    localparam logic       FUNC_PIXEL = 1'b1;

    typedef struct packed {
        logic               is_write;
        logic [CODE_W-1:0]  index;
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   count;
    } rpd_cmd_t;

    function automatic logic idx_in_range(input logic [CODE_W-1:0] idx);
        idx_in_range = ({1'b0, idx} < (CODE_W + 1)'(PAL_ENTRIES));
    endfunction

endpackage

// ===== hdl/rpd_front.sv =====
// Front end: accepts input transactions, tracks a pending run code and turns literal bytes,
// the index bytes of non-empty runs and in-range palette writes into commands. Depends on rpd_pkg.
module rpd_front
    import rpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [CODE_W-1:0]  code_byte,
    input  logic [CODE_W-1:0]  entry_index,
    input  logic [COLOR_W-1:0] entry_color,
    output logic               cmd_push,
    output rpd_cmd_t           cmd,
    input  logic               cmd_full
);

    logic             run_pending_reg;
    logic [CNT_W-1:0] run_length_reg;
    logic             accept;
    logic             is_mark;

    assign full    = cmd_full;
    assign accept  = push && !cmd_full;
    assign is_mark = (code_byte[CODE_W-1:CODE_W-2] == RUN_MARK);

    always_comb
    begin
        cmd.is_write = (func == FUNC_WRITE);
        cmd.color    = entry_color;
        if (func == FUNC_WRITE)
        begin
            cmd.index = entry_index;
            cmd.count = '0;
            cmd_push  = accept && idx_in_range(entry_index);
        end
        else
        begin
            cmd.index = code_byte;
            if (run_pending_reg)
            begin
                cmd.count = run_length_reg;
                cmd_push  = accept && (run_length_reg != '0);
            end
            else
            begin
                cmd.count = CNT_W'(1);
                cmd_push  = accept && !is_mark;
            end
        end
    end

    // arm a run on a run code, drop it once its index byte arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pending_reg <= 1'b0;
            run_length_reg  <= '0;
        end
        else if (accept && (func == FUNC_PIXEL))
        begin
            if (run_pending_reg)
            begin
                run_pending_reg <= 1'b0;
                run_length_reg  <= '0;
            end
            else if (is_mark)
            begin
                run_pending_reg <= 1'b1;
                run_length_reg  <= code_byte[CNT_W-1:0];
            end
        end
    end

endmodule

// ===== hdl/rpd_cmd_fifo.sv =====
// Two-entry command queue between front end and back end.
// Depends on rpd_pkg.
module rpd_cmd_fifo
    import rpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_push,
    input  rpd_cmd_t in_cmd,
    output logic     full,
    output logic     out_valid,
    output rpd_cmd_t out_cmd,
    input  logic     out_pop
);

    rpd_cmd_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = in_push && !full;
    assign do_pop    = out_pop && out_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/rpd_back.sv =====
// Back end: palette memory, a read stage and an output stage that repeats a colour
// for the length of a run. Depends on rpd_pkg.
module rpd_back
    import rpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  rpd_cmd_t    cmd,
    output logic        cmd_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        run_last
);

    logic [COLOR_W-1:0] palette_mem [PAL_ENTRIES];
    logic [COLOR_W-1:0] rdata_reg;
    logic               s1_valid_reg;
    logic [CNT_W-1:0]   s1_count_reg;
    logic               s1_oor_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               s2_free;
    logic               s2_load;
    logic               s1_take;
    logic               out_take;

    assign empty    = (out_cnt_reg == '0);
    assign out_take = pop && !empty;
    assign s2_free  = empty || ((out_cnt_reg == CNT_W'(1)) && pop);
    assign s2_load  = s1_valid_reg && s2_free;
    assign s1_take  = !s1_valid_reg || s2_load;
    assign cmd_pop  = cmd_valid && (cmd.is_write || s1_take);

    assign red      = out_color_reg[23:16];
    assign green    = out_color_reg[15:8];
    assign blue     = out_color_reg[7:0];
    assign run_last = (out_cnt_reg == CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd.is_write)
        begin
            palette_mem[cmd.index[PAL_IDX_W-1:0]] <= cmd.color;
        end
        if (cmd_valid && !cmd.is_write && s1_take)
        begin
            rdata_reg <= palette_mem[cmd.index[PAL_IDX_W-1:0]];
        end
        if (s1_take)
        begin
            s1_count_reg <= cmd.count;
            s1_oor_reg   <= !idx_in_range(cmd.index);
        end
        if (s2_load)
        begin
            out_color_reg <= s1_oor_reg ? '0 : rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= cmd_valid && !cmd.is_write;
            end
            if (s2_load)
            begin
                out_cnt_reg <= s1_count_reg;
            end
            else if (out_take)
            begin
                out_cnt_reg <= out_cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/pcx_rle_palette_decoder.sv =====
// Top level of the PCX run-length palette decoder.
// Depends on rpd_pkg, rpd_front, rpd_cmd_fifo and rpd_back.
//
//   channel   direction  handshake     payload
//   input     in         push / full   func, code_byte, entry_index, entry_color
//   result    out        empty / pop   red, green, blue, run_last
//
// A literal byte gives one pixel per cycle while pop is high; a run of count n
// gives n pixels, one per pop, set by the repeat counter in the back end.
// Run codes, zero-length runs and palette writes produce no pixel; writes do not
// wait on the read stage. Pixels pass the queue, the read and the output stage.
// Reset clears the run state and all queues; the palette is not cleared.
// Input stalls (full high) when the two-entry command queue fills behind a run
// or a stalled pop.
module pcx_rle_palette_decoder
    import rpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [CODE_W-1:0]  code_byte,
    input  logic [CODE_W-1:0]  entry_index,
    input  logic [COLOR_W-1:0] entry_color,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic               run_last
);

    // front end to queue
    rpd_cmd_t front_cmd;
    logic     front_push;
    logic     queue_full;

    // queue to back end
    rpd_cmd_t head_cmd;
    logic     head_valid;
    logic     head_pop;

    // classify each input transaction and hold the pending run
    rpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .code_byte   (code_byte),
        .entry_index (entry_index),
        .entry_color (entry_color),
        .cmd_push    (front_push),
        .cmd         (front_cmd),
        .cmd_full    (queue_full)
    );

    // decouple the two sides so a long run does not block the front at once
    rpd_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (front_push),
        .in_cmd    (front_cmd),
        .full      (queue_full),
        .out_valid (head_valid),
        .out_cmd   (head_cmd),
        .out_pop   (head_pop)
    );

    // write the palette, look up colours and expand runs into pixels
    rpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (head_pop),
        .empty     (empty),
        .pop       (pop),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .run_last  (run_last)
    );

endmodule
